// File: rtl/core/sfa_pkg.sv
// ----------------------------------------------------------------------------
// Sensor array frame averager package
// Shared widths, defaults, register codes and routing tables.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

    localparam int DEF_NUM_SENSORS    = 36;
    localparam int DEF_NUM_CONVERTERS = 5;
    localparam int DEF_SAMPLE_BITS    = 16;

    localparam int RAW_W     = 16;
    localparam int SUM_W     = 24;
    localparam int FRAME_W   = 8;
    localparam int IDX_W     = 6;
    localparam int Q20_W     = 32;
    localparam int Q4_W      = 16;
    localparam int Q4_SHIFT  = 16;
    localparam int FRAC_BITS = 20;
    localparam int POS_W     = 3;
    localparam int INPUTS_PER_CONV = 8;

    localparam int DIV_STEPS  = SUM_W + FRAC_BITS;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [0:0] REG_FRAMES_TO_AVERAGE = 1'b0;
    localparam logic [FRAME_W-1:0] FRAMES_RESET = 8'd64;

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t FULL_ROUTE [INPUTS_PER_CONV] = '{
        3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd2, 3'd1, 3'd0
    };
    localparam pos_t TAIL_ROUTE [INPUTS_PER_CONV] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0
    };

endpackage

`default_nettype wire

// File: rtl/core/sfa_if.sv
// ----------------------------------------------------------------------------
// Sensor array frame averager channels
// Valid/ready channels for raw samples and averaged results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfa_sample_if;
    logic                     valid;
    logic                     ready;
    logic [sfa_pkg::RAW_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink (input valid, input raw_sample, output ready);
endinterface

interface sfa_result_if;
    logic                       valid;
    logic                       ready;
    logic [sfa_pkg::IDX_W-1:0]  sensor_index;
    logic [sfa_pkg::Q20_W-1:0]  average_q20;
    logic [sfa_pkg::Q4_W-1:0]   average_q4;
    logic                       last_sensor;

    modport source (
        output valid, output sensor_index, output average_q20,
        output average_q4, output last_sensor, input ready
    );
    modport sink (
        input valid, input sensor_index, input average_q20,
        input average_q4, input last_sensor, output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/sensor_array_frame_averager.sv
// ----------------------------------------------------------------------------
// Sensor array frame averager
// Routes converter samples to sensor accumulators and emits bit-serial
// divided averages in Q20 and Q4 after the configured number of frames.
// ----------------------------------------------------------------------------
// Each sample is read from its accumulator in S_IDLE and written back in S_ACC.
// The sample that completes the last frame is written back, then each sensor
// in turn is read, loaded, run through the 44-step bit-serial divider and
// handed off, waiting out any result stall; only then is the input ready again.
// Reset clears the scan position, the frame count and the accumulator valid
// bits, so all sums read as zero; frames_to_average resets to 64.
`default_nettype none

module sensor_array_frame_averager #(
    parameter int NUM_SENSORS    = sfa_pkg::DEF_NUM_SENSORS,
    parameter int NUM_CONVERTERS = sfa_pkg::DEF_NUM_CONVERTERS,
    parameter int SAMPLE_BITS    = sfa_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sfa_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [sfa_pkg::PDATA_W-1:0]   pwdata,
    output logic      [sfa_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    sfa_sample_if.sink                         samples,
    sfa_result_if.source                       results
);

    localparam int SLOT_W    = $clog2(NUM_SENSORS);
    localparam int TAIL_REST = NUM_SENSORS - 8 * (NUM_CONVERTERS - 1);
    localparam int TAIL_INPUTS = (TAIL_REST < 1) ? 1 : ((TAIL_REST > 8) ? 8 : TAIL_REST);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ACC      = 3'd1;
    localparam logic [2:0] S_EMIT_RD  = 3'd2;
    localparam logic [2:0] S_EMIT_LD  = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_DIV_DONE = 3'd5;

    logic [2:0]                         state_reg, state_next;
    sfa_pkg::pos_t                      conv_reg, conv_next;
    sfa_pkg::pos_t                      inp_reg, inp_next;
    logic [sfa_pkg::FRAME_W-1:0]        frames_done_reg, frames_done_next;
    logic [sfa_pkg::FRAME_W-1:0]        fta_reg, fta_next;
    logic                               emit_reg, emit_next;
    logic [NUM_SENSORS-1:0]             valid_reg, valid_next;
    logic [SLOT_W-1:0]                  sensor_cnt_reg, sensor_cnt_next;
    logic [sfa_pkg::DIV_STEP_W-1:0]     step_cnt_reg, step_cnt_next;
    logic                               out_valid_reg, out_valid_next;

    logic [sfa_pkg::FRAME_W-1:0]        divisor_reg, divisor_next;
    logic [SLOT_W-1:0]                  slot_idx_reg, slot_idx_next;
    logic                               hit_reg, hit_next;
    logic [SAMPLE_BITS-1:0]             sample_reg, sample_next;
    sfa_pkg::sum_t                      dvd_reg, dvd_next;
    logic [sfa_pkg::FRAME_W-1:0]        rem_reg, rem_next;
    logic [sfa_pkg::Q20_W-1:0]          quo_reg, quo_next;
    logic [sfa_pkg::IDX_W-1:0]          out_index_reg, out_index_next;
    logic [sfa_pkg::Q20_W-1:0]          out_q20_reg, out_q20_next;
    logic                               out_last_reg, out_last_next;

    sfa_pkg::sum_t                      sum_mem [NUM_SENSORS];
    sfa_pkg::sum_t                      rd_data_reg;
    logic [SLOT_W-1:0]                  rd_addr;
    logic                               mem_we;
    sfa_pkg::sum_t                      wr_data;

    logic                               last_conv;
    logic                               inp_end;
    sfa_pkg::pos_t                      route;
    logic [sfa_pkg::IDX_W-1:0]          slot;
    logic                               in_range;
    logic [sfa_pkg::FRAME_W-1:0]        done_count;
    logic [sfa_pkg::FRAME_W-1:0]        target;
    logic [sfa_pkg::FRAME_W:0]          rem_shift;
    logic [sfa_pkg::FRAME_W:0]          rem_diff;
    logic                               rem_ge;
    logic                               out_free;
    logic                               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == sfa_pkg::REG_FRAMES_TO_AVERAGE);
    assign prdata    = (paddr[2] == sfa_pkg::REG_FRAMES_TO_AVERAGE)
                       ? {{(sfa_pkg::PDATA_W - sfa_pkg::FRAME_W){1'b0}}, fta_reg}
                       : '0;

    assign samples.ready        = (state_reg == S_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.sensor_index = out_index_reg;
    assign results.average_q20  = out_q20_reg;
    assign results.average_q4   = out_q20_reg[sfa_pkg::Q20_W-1:sfa_pkg::Q4_SHIFT];
    assign results.last_sensor  = out_last_reg;

    assign out_free   = !out_valid_reg || results.ready;
    assign last_conv  = ({1'b0, conv_reg} >= 4'(NUM_CONVERTERS - 1));
    assign inp_end    = last_conv ? (inp_reg == 3'(TAIL_INPUTS - 1)) : (inp_reg == 3'd7);
    assign route      = last_conv ? sfa_pkg::TAIL_ROUTE[inp_reg] : sfa_pkg::FULL_ROUTE[inp_reg];
    assign slot       = {conv_reg, route};
    assign in_range   = ({1'b0, slot} < 7'(NUM_SENSORS));
    assign done_count = frames_done_reg + 8'd1;
    assign target     = (fta_reg == '0) ? 8'd1 : fta_reg;
    assign rem_shift  = {rem_reg, dvd_reg[sfa_pkg::SUM_W-1]};
    assign rem_diff   = rem_shift - {1'b0, divisor_reg};
    assign rem_ge     = (rem_shift >= {1'b0, divisor_reg});
    assign rd_addr    = (state_reg == S_IDLE) ? slot[SLOT_W-1:0] : sensor_cnt_reg;

    always_comb
    begin
        state_next       = state_reg;
        conv_next        = conv_reg;
        inp_next         = inp_reg;
        frames_done_next = frames_done_reg;
        fta_next         = cfg_write ? pwdata[sfa_pkg::FRAME_W-1:0] : fta_reg;
        emit_next        = emit_reg;
        valid_next       = valid_reg;
        sensor_cnt_next  = sensor_cnt_reg;
        step_cnt_next    = step_cnt_reg;
        out_valid_next   = out_valid_reg && !results.ready;
        divisor_next     = divisor_reg;
        slot_idx_next    = slot_idx_reg;
        hit_next         = hit_reg;
        sample_next      = sample_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        out_index_next   = out_index_reg;
        out_q20_next     = out_q20_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        wr_data          = (valid_reg[slot_idx_reg] ? rd_data_reg : '0)
                           + sfa_pkg::SUM_W'(sample_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    slot_idx_next = slot[SLOT_W-1:0];
                    hit_next      = in_range;
                    sample_next   = samples.raw_sample[SAMPLE_BITS-1:0];
                    emit_next     = 1'b0;
                    state_next    = S_ACC;
                    if (!inp_end)
                    begin
                        inp_next = inp_reg + 3'd1;
                    end
                    else if (!last_conv)
                    begin
                        inp_next  = '0;
                        conv_next = conv_reg + 3'd1;
                    end
                    else
                    begin
                        inp_next  = '0;
                        conv_next = '0;
                        if (done_count < target)
                        begin
                            frames_done_next = done_count;
                        end
                        else
                        begin
                            frames_done_next = '0;
                            divisor_next     = done_count;
                            emit_next        = 1'b1;
                        end
                    end
                end
            end
            S_ACC:
            begin
                mem_we = hit_reg;
                if (hit_reg)
                begin
                    valid_next[slot_idx_reg] = 1'b1;
                end
                sensor_cnt_next = '0;
                state_next      = emit_reg ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                dvd_next                   = valid_reg[sensor_cnt_reg] ? rd_data_reg : '0;
                valid_next[sensor_cnt_reg] = 1'b0;
                rem_next                   = '0;
                quo_next                   = '0;
                step_cnt_next              = '0;
                state_next                 = S_DIV;
            end
            S_DIV:
            begin
                dvd_next      = {dvd_reg[sfa_pkg::SUM_W-2:0], 1'b0};
                rem_next      = rem_ge ? rem_diff[sfa_pkg::FRAME_W-1:0]
                                       : rem_shift[sfa_pkg::FRAME_W-1:0];
                quo_next      = {quo_reg[sfa_pkg::Q20_W-2:0], rem_ge};
                step_cnt_next = step_cnt_reg + sfa_pkg::DIV_STEP_W'(1);
                if (step_cnt_reg == sfa_pkg::DIV_STEP_W'(sfa_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DIV_DONE;
                end
            end
            S_DIV_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = sfa_pkg::IDX_W'(sensor_cnt_reg);
                    out_q20_next   = quo_reg;
                    out_last_next  = (sensor_cnt_reg == SLOT_W'(NUM_SENSORS - 1));
                    if (sensor_cnt_reg == SLOT_W'(NUM_SENSORS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sensor_cnt_next = sensor_cnt_reg + SLOT_W'(1);
                        state_next      = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            conv_reg        <= '0;
            inp_reg         <= '0;
            frames_done_reg <= '0;
            fta_reg         <= sfa_pkg::FRAMES_RESET;
            emit_reg        <= 1'b0;
            valid_reg       <= '0;
            sensor_cnt_reg  <= '0;
            step_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            conv_reg        <= conv_next;
            inp_reg         <= inp_next;
            frames_done_reg <= frames_done_next;
            fta_reg         <= fta_next;
            emit_reg        <= emit_next;
            valid_reg       <= valid_next;
            sensor_cnt_reg  <= sensor_cnt_next;
            step_cnt_reg    <= step_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg   <= divisor_next;
        slot_idx_reg  <= slot_idx_next;
        hit_reg       <= hit_next;
        sample_reg    <= sample_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        out_index_reg <= out_index_next;
        out_q20_reg   <= out_q20_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[slot_idx_reg] <= wr_data;
        end
        rd_data_reg <= sum_mem[rd_addr];
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < divisor_reg))
        else $error("Divider remainder reached the divisor.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_RD) |-> (divisor_reg != '0))
        else $error("Averaging run started with a zero frame count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && sensor_cnt_reg == SLOT_W'(NUM_SENSORS - 1))
        |-> (valid_reg == '0))
        else $error("Accumulators not all cleared by the final sensor.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg)
        |-> (out_index_reg == sfa_pkg::IDX_W'(NUM_SENSORS - 1)))
        else $error("Last flag on a sensor other than the final one.");
`endif

endmodule

`default_nettype wire

// File: verif/tb_sensor_array_frame_averager.sv
// ----------------------------------------------------------------------------
// Testbench for the sensor array frame averager
// Feeds converter samples in scan order and writes the frame count over
// the APB port. Each averaged result is compared field by field against a
// local model of the routing, accumulation and Q20 division, or against
// fixed table values. A short table of single-frame cases runs first,
// then random phases, all but one with stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sensor_array_frame_averager;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT      = sfa_pkg::DEF_NUM_SENSORS;
    localparam int CONVERTER_COUNT = sfa_pkg::DEF_NUM_CONVERTERS;
    localparam int TAIL_INPUTS     = SLOT_COUNT - 8 * (CONVERTER_COUNT - 1);
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_CYCLES     = 4000;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_ITEMS    = 256;

    localparam logic [sfa_pkg::PADDR_W-1:0] FRAMES_ADDR =
        sfa_pkg::PADDR_W'(4 * int'(sfa_pkg::REG_FRAMES_TO_AVERAGE));

    localparam int FULL_SCAN_SLOT [8] = '{3, 4, 5, 6, 7, 2, 1, 0};
    localparam int TAIL_SCAN_SLOT [8] = '{0, 1, 2, 3, 0, 0, 0, 0};

    typedef enum logic [1:0] {PAT_ZERO, PAT_FULL, PAT_WALK, PAT_RAMP} frame_pattern_t;

    typedef struct packed {
        logic [7:0]     frames_cfg;
        frame_pattern_t pattern;
        logic           typed;
        logic [31:0]    q20;
        logic [15:0]    q4;
    } frame_case_t;

    localparam frame_case_t FRAME_CASES [4] = '{
        '{8'd1,   PAT_FULL, 1'b1, 32'hFFF0_0000, 16'hFFF0},
        '{8'd0,   PAT_ZERO, 1'b1, 32'h0000_0000, 16'h0000},
        '{8'd255, PAT_WALK, 1'b0, 32'h0000_0000, 16'h0000},
        '{8'd1,   PAT_RAMP, 1'b0, 32'h0000_0000, 16'h0000}
    };

    typedef struct packed {
        logic [sfa_pkg::IDX_W-1:0] index;
        logic [sfa_pkg::Q20_W-1:0] q20;
        logic [sfa_pkg::Q4_W-1:0]  q4;
        logic                      last;
    } sensor_average_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [sfa_pkg::PADDR_W-1:0] paddr;
    logic [sfa_pkg::PDATA_W-1:0] pwdata;
    logic [sfa_pkg::PDATA_W-1:0] prdata;
    logic pready;

    sfa_sample_if sample_ch ();
    sfa_result_if result_ch ();

    sensor_average_t pending_averages [$];
    logic [sfa_pkg::SUM_W-1:0] slot_sums [SLOT_COUNT];
    int unsigned scan_conv;
    int unsigned scan_input;
    int unsigned frames_summed;
    logic [7:0] frame_target;

    bit typed_active;
    logic [31:0] typed_q20;
    logic [15:0] typed_q4;

    bit steady_flow;
    int hold_requests;
    int error_count;
    int unsigned cycle_count;

    sensor_array_frame_averager DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (sample_ch),
        .results (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic void accumulate_sample(input logic [15:0] raw);
        int unsigned slot;
        int unsigned inputs_here;
        int unsigned done;
        int unsigned divisor;
        logic [63:0] scaled;
        sensor_average_t avg;
        bit tail;
        tail = (scan_conv == CONVERTER_COUNT - 1);
        slot = scan_conv * 8 + (tail ? TAIL_SCAN_SLOT[scan_input] : FULL_SCAN_SLOT[scan_input]);
        if (slot < SLOT_COUNT)
            slot_sums[slot] = slot_sums[slot] + raw;
        inputs_here = tail ? TAIL_INPUTS : 8;
        scan_input++;
        if (scan_input >= inputs_here)
        begin
            scan_input = 0;
            scan_conv++;
        end
        if (scan_conv < CONVERTER_COUNT)
            return;
        scan_conv = 0;
        done = frames_summed + 1;
        divisor = (frame_target == 8'd0) ? 1 : frame_target;
        if (done < divisor)
        begin
            frames_summed = done;
            return;
        end
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            scaled = {40'd0, slot_sums[k]} << 20;
            scaled = scaled / done;
            avg.index = sfa_pkg::IDX_W'(k);
            avg.q20 = typed_active ? typed_q20 : scaled[31:0];
            avg.q4 = typed_active ? typed_q4 : scaled[31:16];
            avg.last = (k == SLOT_COUNT - 1);
            pending_averages.push_back(avg);
            slot_sums[k] = '0;
        end
        frames_summed = 0;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        sensor_average_t want;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                accumulate_sample(sample_ch.raw_sample);
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_averages.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none actual sensor %0d q20 0x%0h",
                             $time, result_ch.sensor_index, result_ch.average_q20);
                end
                else
                begin
                    want = pending_averages.pop_front();
                    check_field("sensor_index", 32'(want.index), 32'(result_ch.sensor_index));
                    check_field("average_q20", want.q20, result_ch.average_q20);
                    check_field("average_q4", 32'(want.q4), 32'(result_ch.average_q4));
                    check_field("last_sensor", 32'(want.last), 32'(result_ch.last_sensor));
                end
            end
        end
    end

    initial
    begin
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 24);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_sensor_array_frame_averager NOT OK");
        $finish;
    end

    task automatic apb_transfer(input logic write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= FRAMES_ADDR;
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_frame_count(input logic [7:0] frames);
        logic [31:0] readback;
        apb_transfer(1'b1, 32'(frames), readback);
        frame_target = frames;
        apb_transfer(1'b0, 32'd0, readback);
        if (readback !== 32'(frames))
        begin
            error_count++;
            $display("%0t: frame count readback, expected 0x%0h actual 0x%0h",
                     $time, frames, readback);
        end
    endtask

    task automatic send_sample(input logic [15:0] raw);
        if (!steady_flow)
            while ($urandom_range(0, 99) < 24)
            begin
                sample_ch.valid <= 1'b0;
                @(negedge clk);
            end
        sample_ch.valid <= 1'b1;
        sample_ch.raw_sample <= raw;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        wait (pending_averages.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] reset_value;
        logic [15:0] raw;
        logic [7:0] frames;
        int random_sent;
        int phase;
        int phase_len;
        int pick;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.raw_sample = '0;
        steady_flow = 1'b0;
        hold_requests = 0;
        error_count = 0;
        typed_active = 1'b0;
        typed_q20 = '0;
        typed_q4 = '0;
        scan_conv = 0;
        scan_input = 0;
        frames_summed = 0;
        frame_target = sfa_pkg::FRAMES_RESET;
        foreach (slot_sums[k])
            slot_sums[k] = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        apb_transfer(1'b0, 32'd0, reset_value);
        if (reset_value !== 32'd64)
        begin
            error_count++;
            $display("%0t: frame count after reset, expected 0x40 actual 0x%0h",
                     $time, reset_value);
        end

        foreach (FRAME_CASES[c])
        begin
            set_frame_count(FRAME_CASES[c].frames_cfg);
            typed_active = FRAME_CASES[c].typed;
            typed_q20 = FRAME_CASES[c].q20;
            typed_q4 = FRAME_CASES[c].q4;
            for (int n = 0; n < SLOT_COUNT; n++)
            begin
                case (FRAME_CASES[c].pattern)
                    PAT_ZERO: raw = 16'h0000;
                    PAT_FULL: raw = 16'hFFFF;
                    PAT_WALK: raw = 16'h0001 << (n % 16);
                    default:  raw = 16'(n * 1800 + 7);
                endcase
                send_sample(raw);
            end
            sample_ch.valid <= 1'b0;
            wait_until_drained();
            typed_active = 1'b0;
        end

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                frames = 8'd0;
            else if (pick == 1)
                frames = 8'd255;
            else if (pick <= 8)
                frames = 8'd1;
            else if (pick <= 12)
                frames = 8'd2;
            else
                frames = 8'($urandom_range(3, 5));
            phase_len = $urandom_range(20, 80);
            case (phase)
                0:
                begin
                    frames = 8'd1;
                    phase_len = 80;
                end
                1:
                begin
                    frames = 8'd2;
                    phase_len = 90;
                end
                2:
                begin
                    frames = 8'd1;
                    phase_len = 80;
                end
                default: ;
            endcase
            set_frame_count(frames);
            if (phase == 0)
                hold_requests++;
            steady_flow = (phase == 1);
            for (int i = 0; i < phase_len; i++)
            begin
                if (phase == 2 && i == 40)
                begin
                    sample_ch.valid <= 1'b0;
                    wait (pending_averages.size() == 0);
                    @(negedge clk);
                end
                case ($urandom_range(0, 7))
                    0: raw = 16'h0000;
                    1: raw = 16'hFFFF;
                    2: raw = 16'h0001 << $urandom_range(0, 15);
                    3: raw = ~(16'h0001 << $urandom_range(0, 15));
                    default: raw = 16'($urandom);
                endcase
                send_sample(raw);
                random_sent++;
            end
            sample_ch.valid <= 1'b0;
            steady_flow = 1'b0;
            wait_until_drained();
            phase++;
        end

        wait (pending_averages.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_averages.size() == 0)
            $display("tb_sensor_array_frame_averager OK");
        else
            $display("tb_sensor_array_frame_averager NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/sfa_pkg.sv
rtl/core/sfa_if.sv
rtl/core/sensor_array_frame_averager.sv
verif/tb_sensor_array_frame_averager.sv
